### rtl/bounded_integer_set_core_macros.svh
// assertion macros for the bounded integer set core
`ifndef BOUNDED_INTEGER_SET_CORE_MACROS_SVH
`define BOUNDED_INTEGER_SET_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define BIS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bis assertion failed");
// next-cycle implication, disabled during reset
`define BIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bis assertion failed");
`else
`define BIS_ASSERT_IMP(label, ante, cons)
`define BIS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/bis_pkg.sv
package bis_pkg;

	// fixed field widths
	localparam int FUNC_W  = 2;
	localparam int VAL_W   = 32;
	localparam int DELTA_W = 10;
	localparam int STAT_W  = 3;
	localparam int ICAP_W  = 9;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_ADJUST = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_ADJUSTED  = 3'd5;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_DONE
	} state_t;

endpackage

### rtl/bounded_integer_set_core.sv
// Set of distinct 32-bit signed values with a count and a movable capacity.
// Input channel (in_valid/in_ready) takes one operation per beat: func,
// value, delta. Output channel (out_valid/out_ready) returns one beat per
// operation with status, capacity and count after the operation.
// cfg_we/cfg_data load the initial capacity; the capacity is updated at
// once, clamped to DEPTH and to the current count. Write it while idle.
// Add and remove scan the store through its single read port, one entry
// per cycle; a match ends the scan early, and a remove that finds its
// value then moves the last entry into the hole before the result is
// ready. An adjust or unused code goes straight from idle to done. One
// operation is in flight at a time; in_ready is high only while the
// sequencer is idle, so the next beat can be taken in the cycle after a
// result is loaded.
// A finished result sits in the output register; the next operation is
// accepted while it waits. If the receiver stalls and a second result is
// ready, the sequencer holds it until the output register frees up.
// Reset clears the count, loads the capacity with min(256, DEPTH) and
// drops out_valid. Store contents are not cleared; only entries below the
// count are ever read.
module bounded_integer_set_core
	import bis_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [FUNC_W-1:0]               func,
	input  logic signed [VAL_W-1:0]         value,
	input  logic signed [DELTA_W-1:0]       delta,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [STAT_W-1:0]               status,
	output logic [$clog2(DEPTH+1)-1:0]      capacity,
	output logic [$clog2(DEPTH+1)-1:0]      count,
	input  logic                            cfg_we,
	input  logic [ICAP_W-1:0]               cfg_data
);

`include "bounded_integer_set_core_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW = (CW > ICAP_W) ? CW : ICAP_W;
	localparam int XW = MW + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] RST_CAP = CW'((DEPTH < 256) ? DEPTH : 256);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     cap_q;
	logic [FUNC_W-1:0] func_q;
	logic [VAL_W-1:0]  val_q;
	logic [CW-1:0]     idx_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [STAT_W-1:0] res_status_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [CW-1:0]     out_cap_q;
	logic [CW-1:0]     out_cnt_q;

	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [VAL_W-1:0]  mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;
	logic [VAL_W-1:0]  mem_rd;

	logic              accept;
	logic              out_free;
	logic              hit;
	logic              scan_more;
	logic              scan_end;
	logic              scan_rd;
	logic              full;
	logic [CW-1:0]     cnt_m1;

	logic signed [XW-1:0] cnt_x;
	logic signed [XW-1:0] dep_x;
	logic signed [XW-1:0] adj_sum;
	logic signed [XW-1:0] cfg_x;
	logic [CW-1:0]        adj_cap;
	logic [CW-1:0]        cfg_cap;

	// element store
	bis_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.re    (mem_re),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	// handshake and scan status
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign hit       = rd_vld_s1 && (mem_rd == val_q);
	assign scan_more = idx_q < count_q;
	assign scan_end  = !hit && !scan_more;
	assign full      = (count_q >= cap_q) || (count_q >= DEPTH_C);
	assign cnt_m1    = count_q - CW'(1);

	// capacity arithmetic for adjust and register write
	assign cnt_x   = $signed(XW'(count_q));
	assign dep_x   = $signed(XW'(DEPTH_C));
	assign adj_sum = $signed(XW'(cap_q)) + XW'(delta);
	assign cfg_x   = $signed(XW'(cfg_data));

	always_comb begin
		if (delta == '0) begin
			adj_cap = cap_q;
		end else if (adj_sum < cnt_x) begin
			adj_cap = count_q;
		end else if (adj_sum > dep_x) begin
			adj_cap = DEPTH_C;
		end else begin
			adj_cap = adj_sum[CW-1:0];
		end
	end

	always_comb begin
		if (cfg_x > dep_x) begin
			cfg_cap = DEPTH_C;
		end else if (cfg_x < cnt_x) begin
			cfg_cap = count_q;
		end else begin
			cfg_cap = cfg_x[CW-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func) inside
						FN_ADD, FN_REMOVE: state_d = S_SCAN;
						default:           state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (func_q == FN_REMOVE) ? S_MOVE : S_DONE;
				end else if (scan_end) begin
					state_d = S_DONE;
				end
			end
			S_MOVE: state_d = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: memory port control
	always_comb begin
		in_ready = 1'b0;
		scan_rd  = 1'b0;
		mem_re   = 1'b0;
		mem_ra   = idx_q[AW-1:0];
		mem_we   = 1'b0;
		mem_wa   = count_q[AW-1:0];
		mem_wd   = val_q;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SCAN: begin
				if (hit) begin
					// fetch the last entry to fill the hole
					if (func_q == FN_REMOVE) begin
						mem_re = 1'b1;
						mem_ra = cnt_m1[AW-1:0];
					end
				end else if (scan_more) begin
					scan_rd = 1'b1;
					mem_re  = 1'b1;
				end else if (func_q == FN_ADD && !full) begin
					mem_we = 1'b1;
				end
			end
			S_MOVE: begin
				mem_we = 1'b1;
				mem_wa = rd_idx_s1;
				mem_wd = mem_rd;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan pointer and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
		end else if (accept) begin
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
		end else if (state_q == S_SCAN) begin
			rd_vld_s1 <= scan_rd;
			if (scan_rd) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		if (accept) begin
			func_q <= func;
			val_q  <= value;
		end
	end

	// count, capacity and pending status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			cap_q        <= RST_CAP;
			res_status_q <= ST_ADJUSTED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						cap_q <= cfg_cap;
					end
					if (in_valid) begin
						res_status_q <= ST_ADJUSTED;
						if (func == FN_ADJUST) begin
							cap_q <= adj_cap;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_status_q <= ST_PRESENT;
					end else if (scan_end) begin
						if (func_q == FN_ADD) begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_ADDED;
								count_q      <= count_q + CW'(1);
							end
						end else begin
							res_status_q <= ST_NOT_FOUND;
							cap_q        <= count_q;
						end
					end
				end
				S_MOVE: begin
					res_status_q <= ST_REMOVED;
					count_q      <= cnt_m1;
					cap_q        <= cnt_m1;
				end
				S_DONE: ;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_cap_q    <= cap_q;
			out_cnt_q    <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign capacity  = out_cap_q;
	assign count     = out_cnt_q;

	// checks
	`BIS_ASSERT_IMP(a_cnt_le_cap, 1'b1, count_q <= cap_q && cap_q <= DEPTH_C)
	`BIS_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE)
	`BIS_ASSERT_NEXT(a_done_loads_out, state_q == S_DONE && out_free, out_valid_q)

endmodule

### rtl/bis_store.sv
module bis_store
	import bis_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
